// ===== src/txrdc_pkg.sv =====
// shared types, constants and chunk helpers for the transmit ring with dma chunking
package txrdc_pkg;

    localparam int RING_DEPTH = 256;
    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int EXT_W = (PTR_W > 8) ? PTR_W : 8;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [EXT_W-1:0] ext_t;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_FETCH = 2'd1,
        REQ_DONE  = 2'd2
    } req_t;

    typedef struct packed {
        logic       accepted;
        logic       chunk_valid;
        logic [7:0] chunk_start;
        logic [7:0] chunk_len;
        logic       busy_flag;
        logic       is_fetch;
    } res_t;

    typedef struct packed {
        logic       wr_en;
        ptr_t       wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        ptr_t       rd_addr;
    } mem_req_t;

    function automatic logic [7:0] chunk_start_f(ptr_t r);
        ext_t e;
        e = ext_t'(r);
        return e[7:0];
    endfunction

    // contiguous length from the read pointer up to the write pointer or the buffer end, saturated to a byte
    function automatic logic [7:0] chunk_len_f(ptr_t w, ptr_t r);
        ptr_t len;
        ext_t e;
        len = (w >= r) ? ptr_t'(w - r) : ptr_t'(ptr_t'(0) - r);
        e = ext_t'(len);
        return (e > ext_t'(8'hFF)) ? 8'hFF : e[7:0];
    endfunction

endpackage

// ===== src/txrdc_ram.sv =====
// simple dual-port synchronous ram with registered read data
module txrdc_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/txrdc_ctrl.sv =====
// ring pointer state, busy tracking and chunk computation
module txrdc_ctrl
    import txrdc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_accept,
    input  req_t       req_type,
    input  logic [7:0] data_byte,
    input  logic       last_of_call,
    input  logic [7:0] fetch_addr,
    input  logic [7:0] done_size,
    output res_t       result,
    output mem_req_t   mem_req
);

    ptr_t wp_reg, wp_next;
    ptr_t rp_reg, rp_next;
    logic busy_reg, busy_next;
    logic stored_reg, stored_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            busy_reg   <= 1'b0;
            stored_reg <= 1'b0;
        end else if (item_accept) begin
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            busy_reg   <= busy_next;
            stored_reg <= stored_next;
        end
    end

    always_comb begin
        ptr_t inc_wp;
        ptr_t held;
        ptr_t done_clamped;
        ext_t done_ext;
        ext_t fetch_ext;
        inc_wp       = wp_reg + ptr_t'(1);
        held         = wp_reg - rp_reg;
        done_ext     = ext_t'(done_size);
        done_clamped = (done_ext > ext_t'(held)) ? held : done_ext[PTR_W-1:0];
        fetch_ext    = ext_t'(fetch_addr);

        wp_next     = wp_reg;
        rp_next     = rp_reg;
        busy_next   = busy_reg;
        stored_next = stored_reg;
        result      = '0;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = wp_reg;
        mem_req.wr_data = data_byte;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = fetch_ext[PTR_W-1:0];

        case (req_type)
            REQ_WRITE: begin
                if (inc_wp != rp_reg) begin
                    wp_next         = inc_wp;
                    stored_next     = 1'b1;
                    result.accepted = 1'b1;
                    mem_req.wr_en   = item_accept;
                end
                if (last_of_call) begin
                    if (!busy_reg && stored_next) begin
                        busy_next          = 1'b1;
                        result.chunk_valid = 1'b1;
                        result.chunk_start = chunk_start_f(rp_reg);
                        result.chunk_len   = chunk_len_f(wp_next, rp_reg);
                    end
                    stored_next = 1'b0;
                end
            end
            REQ_FETCH: begin
                result.is_fetch = 1'b1;
                mem_req.rd_en   = item_accept;
            end
            REQ_DONE: begin
                if (busy_reg) begin
                    rp_next = rp_reg + done_clamped;
                    if (rp_next != wp_reg) begin
                        result.chunk_valid = 1'b1;
                        result.chunk_start = chunk_start_f(rp_next);
                        result.chunk_len   = chunk_len_f(wp_reg, rp_next);
                    end else begin
                        busy_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        result.busy_flag = busy_next;
    end

    a_busy_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rp_reg != wp_reg))
        else $error("transfer busy with an empty ring");

    a_chunk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_accept && result.chunk_valid) |-> (result.chunk_len != 8'd0))
        else $error("chunk issued with zero length");

    a_rp_moves_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (rp_reg != $past(rp_reg)) |-> $past(item_accept && req_type == REQ_DONE))
        else $error("read pointer moved without a completion");

    a_wp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (wp_reg != $past(wp_reg)) |-> (wp_reg == $past(wp_reg) + ptr_t'(1)))
        else $error("write pointer moved by more than one slot");

endmodule

// ===== src/tx_ring_with_dma_chunks.sv =====
// top level of the transmit ring buffer with dma chunk issue
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser req_type, s_tdata bytes, s_tlast last_of_call
//  m_      | out | m_tvalid/m_tready  | m_tdata result fields
//
// every item gives one result, held in the read stage and then the output register; a new item is taken
// each cycle unless a stalled m_ side fills both; the pacing stage is the registered read of the ring memory
// aresetn clears pointers, busy and handshake state; ring contents stay unknown until written
// a stalled m_ side holds one result in the output register and one in the read stage
// after which s_tready drops until the output register is taken
module tx_ring_with_dma_chunks
    import txrdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // data_byte[7:0], fetch_addr[15:8], done_size[23:16]
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // accepted[0], chunk_valid[1], chunk_start[9:2],
                                  // chunk_len[17:10], fetch_data[25:18], busy_flag[26]
);

    logic       item_accept;
    logic       out_load;
    res_t       result;
    mem_req_t   mem_req;
    logic [7:0] rd_data;

    logic        pend_valid_reg, pend_valid_next;
    res_t        pend_res_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    txrdc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_accept  (item_accept),
        .req_type     (req_t'(s_tuser)),
        .data_byte    (s_tdata[7:0]),
        .last_of_call (s_tlast),
        .fetch_addr   (s_tdata[15:8]),
        .done_size    (s_tdata[23:16]),
        .result       (result),
        .mem_req      (mem_req)
    );

    txrdc_ram #(
        .DATA_W (8),
        .ADDR_W (PTR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    assign out_load    = pend_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = aresetn && (!pend_valid_reg || out_load);
    assign item_accept = s_tvalid && s_tready;

    always_comb begin
        logic [7:0] fdata;
        fdata = pend_res_reg.is_fetch ? rd_data : 8'd0;

        pend_valid_next = item_accept ? 1'b1 : (out_load ? 1'b0 : pend_valid_reg);
        out_valid_next  = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_data_next   = {5'd0, pend_res_reg.busy_flag, fdata, pend_res_reg.chunk_len,
                           pend_res_reg.chunk_start, pend_res_reg.chunk_valid,
                           pend_res_reg.accepted};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_accept) begin
            pend_res_reg <= result;
        end
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_out_from_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(pend_valid_reg))
        else $error("result appeared without a pending transaction");

    a_no_pend_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && out_valid_reg && !m_tready) |=> pend_valid_reg)
        else $error("pending result lost while output stalled");

endmodule

// ===== tb/tx_ring_chunk_checker.sv =====
// transaction checker that predicts and compares the transmit ring results
`timescale 1ns / 1ps

module tx_ring_chunk_checker
    import txrdc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [23:0]           s_tdata,  // data_byte[7:0], fetch_addr[15:8], done_size[23:16]
    input  logic [1:0]            s_tuser,  // req_type[1:0]
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,  // accepted[0], chunk_valid[1], chunk_start[9:2],
                                            // chunk_len[17:10], fetch_data[25:18], busy_flag[26]
    output int                    err_count,
    output int                    pending_cnt,
    output logic [RING_DEPTH-1:0] written_map,
    output logic                  busy_now,
    output int                    chunk_seq,
    output int                    chunk_first,
    output int                    chunk_size
);

    typedef struct packed {
        logic       accepted;
        logic       chunk_valid;
        logic [7:0] chunk_start;
        logic [7:0] chunk_len;
        logic [7:0] fetch_data;
        logic       busy_flag;
    } tx_result_t;

    tx_result_t            pending_results[$];
    logic [7:0]            ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] slot_written;
    int unsigned           wr_pos;
    int unsigned           rd_pos;
    bit                    xfer_busy;
    bit                    call_stored;
    int                    errs;
    int                    seq;
    int                    cur_first;
    int                    cur_len;

    function automatic int unsigned bytes_held();
        return (wr_pos >= rd_pos) ? wr_pos - rd_pos : RING_DEPTH - rd_pos + wr_pos;
    endfunction

    // next contiguous chunk from the read side, cut at the buffer end
    function automatic void issue_chunk(ref tx_result_t res);
        int unsigned len;
        len = (wr_pos >= rd_pos) ? wr_pos - rd_pos : RING_DEPTH - rd_pos;
        if (len > 255)
            len = 255;
        res.chunk_valid = 1'b1;
        res.chunk_start = rd_pos[7:0];
        res.chunk_len   = len[7:0];
        seq++;
        cur_first = rd_pos;
        cur_len   = len;
    endfunction

    function automatic tx_result_t advance_ring(logic [1:0] kind, logic [7:0] data_b, logic last,
                                                logic [7:0] faddr, logic [7:0] done_sz);
        tx_result_t  res;
        int unsigned nxt;
        int unsigned done;
        res = '0;
        case (kind)
            REQ_WRITE: begin
                nxt = (wr_pos + 1) % RING_DEPTH;
                if (nxt != rd_pos) begin
                    ring_mem[wr_pos[PTR_W-1:0]]     = data_b;
                    slot_written[wr_pos[PTR_W-1:0]] = 1'b1;
                    wr_pos                          = nxt;
                    call_stored                     = 1'b1;
                    res.accepted                    = 1'b1;
                end
                if (last) begin
                    if (!xfer_busy && call_stored) begin
                        xfer_busy = 1'b1;
                        issue_chunk(res);
                    end
                    call_stored = 1'b0;
                end
            end
            REQ_FETCH: begin
                res.fetch_data = ring_mem[PTR_W'(faddr)];
            end
            REQ_DONE: begin
                if (xfer_busy) begin
                    done = 32'(done_sz);
                    if (done > bytes_held())
                        done = bytes_held();
                    rd_pos = (rd_pos + done) % RING_DEPTH;
                    if (rd_pos != wr_pos)
                        issue_chunk(res);
                    else
                        xfer_busy = 1'b0;
                end
            end
            default: ;
        endcase
        res.busy_flag = xfer_busy;
        return res;
    endfunction

    always @(posedge aclk) begin
        tx_result_t exp_r;
        tx_result_t got_r;
        if (!aresetn) begin
            pending_results.delete();
            slot_written = '0;
            wr_pos       = 0;
            rd_pos       = 0;
            xfer_busy    = 1'b0;
            call_stored  = 1'b0;
            errs         = 0;
            seq          = 0;
            cur_first    = 0;
            cur_len      = 0;
        end else begin
            if (s_tvalid && s_tready)
                pending_results.push_back(advance_ring(s_tuser, s_tdata[7:0], s_tlast,
                                                       s_tdata[15:8], s_tdata[23:16]));
            if (m_tvalid && m_tready) begin
                got_r.accepted    = m_tdata[0];
                got_r.chunk_valid = m_tdata[1];
                got_r.chunk_start = m_tdata[9:2];
                got_r.chunk_len   = m_tdata[17:10];
                got_r.fetch_data  = m_tdata[25:18];
                got_r.busy_flag   = m_tdata[26];
                if (pending_results.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected result transaction: %h", m_tdata);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got_r.accepted !== exp_r.accepted
                        || got_r.chunk_valid !== exp_r.chunk_valid
                        || got_r.chunk_start !== exp_r.chunk_start
                        || got_r.chunk_len !== exp_r.chunk_len
                        || got_r.fetch_data !== exp_r.fetch_data
                        || got_r.busy_flag !== exp_r.busy_flag) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("mismatch: exp acc=%0d cv=%0d start=%0d len=%0d fd=%h busy=%0d",
                                     exp_r.accepted, exp_r.chunk_valid, exp_r.chunk_start,
                                     exp_r.chunk_len, exp_r.fetch_data, exp_r.busy_flag);
                            $display("          got acc=%0d cv=%0d start=%0d len=%0d fd=%h busy=%0d",
                                     got_r.accepted, got_r.chunk_valid, got_r.chunk_start,
                                     got_r.chunk_len, got_r.fetch_data, got_r.busy_flag);
                        end
                    end
                end
            end
        end
        err_count   <= errs;
        pending_cnt <= pending_results.size();
        written_map <= slot_written;
        busy_now    <= xfer_busy;
        chunk_seq   <= seq;
        chunk_first <= cur_first;
        chunk_size  <= cur_len;
    end

endmodule

// ===== tb/tb_tx_ring_with_dma_chunks.sv =====
// testbench top for the transmit ring with dma chunking: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_tx_ring_with_dma_chunks
    import txrdc_pkg::*;
;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         RAND_ITEMS  = 1320;
    localparam int         DRAIN_EVERY = 400;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // data_byte[7:0], fetch_addr[15:8], done_size[23:16]
    logic [1:0]  s_tuser  = '0;  // req_type[1:0]
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // accepted[0], chunk_valid[1], chunk_start[9:2],
                                 // chunk_len[17:10], fetch_data[25:18], busy_flag[26]

    int                    err_count;
    int                    pending_cnt;
    logic [RING_DEPTH-1:0] written_map;
    logic                  busy_now;
    int                    chunk_seq;
    int                    chunk_first;
    int                    chunk_size;

    int sent_cnt   = 0;
    int done_seq   = 0;
    int quiet_left = 0;
    int ready_left = 0;
    int idle_cycles = 0;

    always #5 aclk = ~aclk;

    tx_ring_with_dma_chunks uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tx_ring_chunk_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .err_count   (err_count),
        .pending_cnt (pending_cnt),
        .written_map (written_map),
        .busy_now    (busy_now),
        .chunk_seq   (chunk_seq),
        .chunk_first (chunk_first),
        .chunk_size  (chunk_size)
    );

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        int r;
        if (ready_left > 0) begin
            ready_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (!m_tready) begin
                m_tready <= 1'b1;
                ready_left = (r < 10) ? $urandom_range(60, 200) : $urandom_range(1, 12);
            end else begin
                m_tready <= 1'b0;
                ready_left = (r < 85) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic sender_gap();
        int gap;
        int r;
        gap = 0;
        r = $urandom_range(0, 99);
        if (quiet_left > 0)
            quiet_left--;
        else if ($urandom_range(0, 199) == 0)
            quiet_left = $urandom_range(30, 80);
        else if (r >= 92)
            gap = $urandom_range(8, 40);
        else if (r >= 65)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [7:0] data_b, input logic last,
                             input logic [7:0] faddr, input logic [7:0] done_sz);
        sender_gap();
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {done_sz, faddr, data_b};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sent_cnt++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_cnt != 0);
    endtask

    task automatic pick_written(output bit found, output logic [7:0] addr);
        int first;
        found = 1'b0;
        addr  = '0;
        first = $urandom_range(0, RING_DEPTH - 1);
        for (int k = 0; k < RING_DEPTH; k++) begin
            if (!found && written_map[PTR_W'(first + k)]) begin
                found = 1'b1;
                addr  = 8'((first + k) % RING_DEPTH);
            end
        end
    endtask

    task automatic send_call();
        int n;
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        for (int k = 0; k < n; k++)
            send_item(REQ_WRITE, rand_byte(), k == n - 1, rand_byte(), rand_byte());
    endtask

    // dma side: read some bytes of the open chunk, then report a completion, usually of the whole chunk
    task automatic run_dma();
        int          len;
        int          first;
        int          n;
        int          r;
        int          slot;
        logic [7:0]  ds;
        len   = chunk_size;
        first = chunk_first;
        n     = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            slot = (first + $urandom_range(0, len - 1)) % RING_DEPTH;
            if (written_map[PTR_W'(slot)])
                send_item(REQ_FETCH, rand_byte(), rand_bit(), 8'(slot), rand_byte());
        end
        r = $urandom_range(0, 99);
        if (r < 80)
            ds = 8'(len);
        else if (r < 92)
            ds = 8'($urandom_range(0, len));
        else
            ds = 8'($urandom_range(len, 255));
        done_seq = chunk_seq;
        send_item(REQ_DONE, rand_byte(), rand_bit(), rand_byte(), ds);
    endtask

    task automatic send_noise();
        bit         found;
        logic [7:0] addr;
        case ($urandom_range(0, 3))
            0: send_item(REQ_UNUSED, rand_byte(), rand_bit(), rand_byte(), rand_byte());
            1: send_item(REQ_DONE, rand_byte(), rand_bit(), rand_byte(), rand_byte());
            2: begin
                pick_written(found, addr);
                if (found)
                    send_item(REQ_FETCH, rand_byte(), rand_bit(), addr, rand_byte());
                else
                    send_call();
            end
            default: send_item(REQ_WRITE, rand_byte(), rand_bit(), rand_byte(), rand_byte());
        endcase
    endtask

    initial begin
        int mode_left;
        int next_drain;
        bit hold;
        mode_left  = 0;
        next_drain = DRAIN_EVERY;
        hold       = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // completion while idle, unknown request kind
        send_item(REQ_DONE, 8'h00, 1'b0, 8'h00, 8'hFF);
        send_item(REQ_UNUSED, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        // first request starts a chunk, a second one while busy does not
        send_item(REQ_WRITE, 8'h00, 1'b0, 8'hFF, 8'h00);
        send_item(REQ_WRITE, 8'hFF, 1'b0, 8'h00, 8'hFF);
        send_item(REQ_WRITE, 8'hA5, 1'b1, 8'h5A, 8'h5A);
        send_item(REQ_WRITE, 8'h5A, 1'b1, 8'hA5, 8'hA5);
        send_item(REQ_FETCH, 8'h12, 1'b0, 8'd0, 8'h00);
        send_item(REQ_FETCH, 8'h34, 1'b1, 8'd1, 8'hFF);
        send_item(REQ_FETCH, 8'h56, 1'b0, 8'd2, 8'h80);
        send_item(REQ_FETCH, 8'h78, 1'b0, 8'd3, 8'h01);
        // zero, partial and oversized completions
        send_item(REQ_DONE, 8'h9A, 1'b0, 8'hC3, 8'd0);
        send_item(REQ_DONE, 8'hBC, 1'b1, 8'h3C, 8'd1);
        send_item(REQ_DONE, 8'hDE, 1'b0, 8'h99, 8'd255);
        send_item(REQ_WRITE, 8'h81, 1'b1, 8'h66, 8'h7E);
        send_item(REQ_FETCH, 8'h00, 1'b0, 8'd4, 8'h00);
        send_item(REQ_DONE, 8'h11, 1'b0, 8'h22, 8'd1);
        send_item(REQ_DONE, 8'h33, 1'b1, 8'h44, 8'd0);
        send_item(REQ_UNUSED, 8'h00, 1'b0, 8'h00, 8'h00);
        drain_results();

        sent_cnt = 0;
        done_seq = chunk_seq;
        while (sent_cnt < RAND_ITEMS) begin
            if (mode_left == 0) begin
                hold      = ($urandom_range(0, 4) == 0);
                mode_left = $urandom_range(40, 80);
            end
            mode_left--;
            if (sent_cnt >= next_drain) begin
                drain_results();
                next_drain += DRAIN_EVERY;
            end
            if ($urandom_range(0, 99) < 8)
                send_noise();
            else if (!hold && busy_now && chunk_seq != done_seq)
                run_dma();
            else
                send_call();
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (err_count == 0 && pending_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
